/* rtl/rpn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RPN calculator package
// Field widths, request and error codes, sequencer and ALU states, the
// structs between sequencer and ALU, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DATA_W  = 32;
	localparam int NUM_W   = 31;
	localparam int REQ_W   = 3;
	localparam int DEPTH_W = 8;
	localparam int ERR_W   = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SUB  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_MUL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DIV  = 3'd4;

	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE,
		ERR_OVERFLOW,
		ERR_UNDERFLOW,
		ERR_DIVZERO
	} err_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_WAIT,
		ST_REPLY
	} calc_state_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_DIVIDE,
		ALU_SIGN,
		ALU_DONE
	} alu_state_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] r);
		logic signed [63:0] sat_max;
		logic signed [63:0] sat_min;
		sat_max = 64'sh0000_0000_7FFF_FFFF;
		sat_min = 64'shFFFF_FFFF_8000_0000;
		if (r > sat_max) begin
			return sat_max[DATA_W-1:0];
		end else if (r < sat_min) begin
			return sat_min[DATA_W-1:0];
		end
		return r[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/rpn_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RPN calculator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rpn_req_if import rpn_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [NUM_W-1:0] number;

	modport source (output valid, output req_type, output number, input ready);
	modport sink (input valid, input req_type, input number, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic                     stack_empty;
	logic [DEPTH_W-1:0]       stack_depth;
	logic [ERR_W-1:0]         error_code;

	modport source (
		output valid, output top_value, output stack_empty,
		output stack_depth, output error_code, input ready
	);
	modport sink (
		input valid, input top_value, input stack_empty,
		input stack_depth, input error_code, output ready
	);
endinterface
`default_nettype wire

/* rtl/rpn_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RPN generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/rpn_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// Add, subtract and multiply are registered on start; signed divide one quotient bit a
// cycle on magnitudes, then sign fix. All results saturate to 32 bits.
// ----------------------------------------------------------------------------
module rpn_alu import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t areq,
	output alu_rsp_t arsp
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	alu_state_t state_q, state_d;

	logic signed [DATA_W-1:0] a_s, b_s;
	logic signed [63:0]       a64, b64, prod, q64;
	logic [DATA_W-1:0]        res_q, rem_q, quo_q, div_q;
	logic                     neg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DATA_W:0]          rem_sh, diff;
	logic                     ge;

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
	endfunction

	assign a_s    = areq.a;
	assign b_s    = areq.b;
	assign a64    = {{32{a_s[DATA_W-1]}}, a_s};
	assign b64    = {{32{b_s[DATA_W-1]}}, b_s};
	assign prod   = a_s * b_s;
	assign q64    = {32'd0, quo_q};
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};
	assign ge     = ~diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ALU_IDLE: begin
				if (areq.start) begin
					state_d = (areq.op == OP_DIV) ? ALU_DIVIDE : ALU_DONE;
				end
			end
			ALU_DIVIDE: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ALU_SIGN;
				end
			end
			ALU_SIGN: state_d = ALU_DONE;
			ALU_DONE: state_d = ALU_IDLE;
			default:  state_d = ALU_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ALU_IDLE && areq.start) begin
			unique case (areq.op)
				OP_ADD: res_q <= sat32(a64 + b64);
				OP_SUB: res_q <= sat32(a64 - b64);
				OP_MUL: res_q <= sat32(prod);
				OP_DIV: begin
					rem_q <= '0;
					quo_q <= mag(areq.a);
					div_q <= mag(areq.b);
					neg_q <= areq.a[DATA_W-1] ^ areq.b[DATA_W-1];
					cnt_q <= '0;
				end
				default: res_q <= '0;
			endcase
		end else if (state_q == ALU_DIVIDE) begin
			rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (state_q == ALU_SIGN) begin
			res_q <= sat32(neg_q ? -q64 : q64);
		end
	end

	assign arsp.done   = (state_q == ALU_DONE);
	assign arsp.result = res_q;

endmodule
`default_nettype wire

/* rtl/rpn_integer_stack_calculator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RPN integer stack calculator
// Reverse-Polish calculator on a bounded operand stack held in RAM.
// ----------------------------------------------------------------------------
// Takes one request item at a time and returns one result item per request:
// top of stack (0 when empty), empty flag, depth and error code. Push, no-op,
// overflow and underflow items pass from DECODE to REPLY; divide by zero
// goes through FETCH as well; add, subtract, multiply and divide also wait
// in WAIT for the shared ALU, whose divider yields one quotient bit per
// cycle. Result valid is raised in REPLY; ready returns the cycle after
// the result is taken. Overflow, underflow and divide by zero leave the stack
// unchanged. The top entry is also held in a register; the entry below it is
// read from the RAM. No clearing pass follows reset.
module rpn_integer_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	rpn_req_if.sink   req,
	rpn_rsp_if.source rsp
);

	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	calc_state_t state_q, state_d;

	logic [PW-1:0]     sp_q, sp_m2;
	logic [DATA_W-1:0] top_q, top_d;
	err_t              err_q, err_d;
	logic              err_ld, top_ld, sp_inc, sp_dec;
	logic [REQ_W-1:0]  req_q;
	logic [NUM_W-1:0]  num_q;
	logic              full, is_div;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;
	logic              in_ready, out_valid;
	logic [31:0]       sp_wide;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	alu_op_t           op;

	assign sp_m2  = sp_q - PW'(2);
	assign full   = (sp_q == PW'(STACK_DEPTH));
	assign is_div = (req_q == REQ_DIV);

	always_comb begin
		unique case (req_q)
			REQ_ADD: op = OP_ADD;
			REQ_SUB: op = OP_SUB;
			REQ_MUL: op = OP_MUL;
			default: op = OP_DIV;
		endcase
	end

	rpn_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.areq   (alu_req),
		.arsp   (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (sp_inc) begin
				sp_q <= sp_q + PW'(1);
			end else if (sp_dec) begin
				sp_q <= sp_q - PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			req_q <= req.req_type;
			num_q <= req.number;
		end
		if (top_ld) begin
			top_q <= top_d;
		end
		if (err_ld) begin
			err_q <= err_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = sp_m2[AW-1:0];
		ram_wdata     = alu_rsp.result;
		ram_re        = 1'b0;
		ram_raddr     = sp_m2[AW-1:0];
		top_ld        = 1'b0;
		top_d         = alu_rsp.result;
		err_ld        = 1'b0;
		err_d         = ERR_NONE;
		sp_inc        = 1'b0;
		sp_dec        = 1'b0;
		alu_req.start = 1'b0;
		alu_req.op    = op;
		alu_req.a     = top_q;
		alu_req.b     = ram_rdata;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				err_ld  = 1'b1;
				state_d = ST_REPLY;
				priority if (req_q == REQ_PUSH) begin
					if (full) begin
						err_d = ERR_OVERFLOW;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = sp_q[AW-1:0];
						ram_wdata = {1'b0, num_q};
						top_ld    = 1'b1;
						top_d     = {1'b0, num_q};
						sp_inc    = 1'b1;
					end
				end else if (req_q == REQ_ADD || req_q == REQ_SUB ||
						req_q == REQ_MUL || req_q == REQ_DIV) begin
					if (sp_q < PW'(2)) begin
						err_d = ERR_UNDERFLOW;
					end else begin
						ram_re  = 1'b1;
						state_d = ST_FETCH;
					end
				end else begin
					err_d = ERR_NONE;
				end
			end
			ST_FETCH: begin
				if (is_div && ram_rdata == '0) begin
					err_ld  = 1'b1;
					err_d   = ERR_DIVZERO;
					state_d = ST_REPLY;
				end else begin
					alu_req.start = 1'b1;
					state_d       = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (alu_rsp.done) begin
					ram_we  = 1'b1;
					top_ld  = 1'b1;
					sp_dec  = 1'b1;
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				out_valid = 1'b1;
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sp_wide = 32'(sp_q);

	assign req.ready       = in_ready;
	assign rsp.valid       = out_valid;
	assign rsp.top_value   = (sp_q != '0) ? top_q : '0;
	assign rsp.stack_empty = (sp_q == '0);
	assign rsp.stack_depth = sp_wide[DEPTH_W-1:0];
	assign rsp.error_code  = err_q;

`ifndef SYNTHESIS
	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request ready while a result item is pending");

	a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == ST_WAIT)
		else $error("ALU result outside the wait state");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLY && err_q == ERR_OVERFLOW) |-> full)
		else $error("overflow reported on a stack that is not full");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECODE && req_q == REQ_PUSH && !full) |=>
		(top_q == {1'b0, $past(num_q)} && sp_q == PW'($past(sp_q) + PW'(1))))
		else $error("push did not update top and depth");
`endif

endmodule
`default_nettype wire

/* dv/tb_rpn_integer_stack_calculator.sv */
// ----------------------------------------------------------------------------
// Testbench for the RPN integer stack calculator
// Drives request items through the request channel and checks every result
// item against a local model of the operand stack. Directed tests cover
// the empty stack, every operation, divide by zero, saturation, overflow
// and underflow. A long random stream follows, with random gaps on both
// channels.
// ----------------------------------------------------------------------------
module tb_rpn_integer_stack_calculator;
	import rpn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 128;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_ITEMS = 150;

	localparam logic [REQ_W-1:0] REQ_NOP    = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] top;
		logic                     empty;
		logic [DEPTH_W-1:0]       depth;
		err_t                     err;
	} calc_result_t;

	logic clk;
	logic arst_n;

	rpn_req_if req_ch ();
	rpn_rsp_if rsp_ch ();

	rpn_integer_stack_calculator #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic signed [DATA_W-1:0] stack_mirror [STACK_DEPTH];
	int                       mirror_depth;
	calc_result_t             pending_results [$];
	calc_result_t             oldest_result;
	int                       mismatches;
	int                       idle_cycles;
	int                       ready_hold;
	bit                       calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [NUM_W-1:0] rand_number();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return NUM_MAX;
			2: return NUM_W'($urandom_range(1, 2));
			3, 4: return NUM_W'($urandom_range(0, 20));
			default: return raw[NUM_W-1:0];
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] rand_kind(int push_pct);
		int r;
		if ($urandom_range(0, 99) < push_pct) begin
			return REQ_PUSH;
		end
		r = $urandom_range(0, 19);
		if (r < 18) begin
			return REQ_W'(1 + r % 4);
		end
		return REQ_W'($urandom_range(REQ_NOP, REQ_SPARE7));
	endfunction

	// Apply one request to the mirrored stack and return the result item.
	function automatic calc_result_t predict_request(logic [REQ_W-1:0] kind,
			logic [NUM_W-1:0] num);
		calc_result_t     res;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] r;
		err_t             err;
		err = ERR_NONE;
		r = '0;
		if (kind == REQ_PUSH) begin
			if (mirror_depth >= STACK_DEPTH) begin
				err = ERR_OVERFLOW;
			end else begin
				stack_mirror[mirror_depth] = {1'b0, num};
				mirror_depth++;
			end
		end else if (kind >= REQ_ADD && kind <= REQ_DIV) begin
			if (mirror_depth < 2) begin
				err = ERR_UNDERFLOW;
			end else begin
				a = stack_mirror[mirror_depth-1];
				b = stack_mirror[mirror_depth-2];
				case (kind)
					REQ_ADD: r = a + b;
					REQ_SUB: r = a - b;
					REQ_MUL: r = a * b;
					default: begin
						if (b == 0) begin
							err = ERR_DIVZERO;
						end else begin
							r = a / b;
						end
					end
				endcase
				if (err == ERR_NONE) begin
					if (r > SAT_HI) begin
						r = SAT_HI;
					end else if (r < SAT_LO) begin
						r = SAT_LO;
					end
					mirror_depth--;
					stack_mirror[mirror_depth-1] = r[DATA_W-1:0];
				end
			end
		end
		res.top = (mirror_depth == 0) ? '0 : stack_mirror[mirror_depth-1];
		res.empty = (mirror_depth == 0);
		res.depth = DEPTH_W'(mirror_depth);
		res.err = err;
		return res;
	endfunction

	task automatic send_request(logic [REQ_W-1:0] kind, logic [NUM_W-1:0] num);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.number <= num;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_request(kind, num));
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			rsp_ch.ready <= 1'b0;
		end else begin
			ready_hold = idle_len();
			rsp_ch.ready <= (ready_hold == 0);
			if (ready_hold > 0) begin
				ready_hold--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with none expected: top_value %0d depth %0d",
					rsp_ch.top_value, rsp_ch.stack_depth);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (rsp_ch.top_value !== oldest_result.top) begin
					$error("top_value: expected %0d, got %0d",
						oldest_result.top, rsp_ch.top_value);
					mismatches++;
				end
				if (rsp_ch.stack_empty !== oldest_result.empty) begin
					$error("stack_empty: expected %0d, got %0d",
						oldest_result.empty, rsp_ch.stack_empty);
					mismatches++;
				end
				if (rsp_ch.stack_depth !== oldest_result.depth) begin
					$error("stack_depth: expected %0d, got %0d",
						oldest_result.depth, rsp_ch.stack_depth);
					mismatches++;
				end
				if (rsp_ch.error_code !== oldest_result.err) begin
					$error("error_code: expected %0d, got %0d",
						oldest_result.err, rsp_ch.error_code);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
		$display("** rpn_integer_stack_calculator: FAILED **");
		$finish;
	end

	task automatic test_empty_stack();
		send_request(REQ_ADD, NUM_MAX);
		send_request(REQ_SUB, '0);
		send_request(REQ_MUL, '0);
		send_request(REQ_DIV, NUM_MAX);
		send_request(REQ_NOP, NUM_MAX);
		send_request(REQ_SPARE6, '0);
		send_request(REQ_SPARE7, NUM_MAX);
	endtask

	task automatic test_arithmetic();
		send_request(REQ_PUSH, 31'd7);
		send_request(REQ_ADD, '0);
		send_request(REQ_PUSH, 31'd3);
		send_request(REQ_SUB, '0);
		send_request(REQ_PUSH, 31'd2);
		send_request(REQ_MUL, '0);
		send_request(REQ_PUSH, 31'd20);
		send_request(REQ_DIV, '0);
		send_request(REQ_PUSH, 31'd0);
		send_request(REQ_PUSH, 31'd5);
		send_request(REQ_DIV, '0);
		send_request(REQ_ADD, '0);
	endtask

	task automatic test_saturation();
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_ADD, '0);
		send_request(REQ_PUSH, 31'd1);
		send_request(REQ_PUSH, 31'd0);
		send_request(REQ_SUB, '0);
		send_request(REQ_PUSH, 31'd1);
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_PUSH, 31'd0);
		send_request(REQ_SUB, '0);
		send_request(REQ_SUB, '0);
		send_request(REQ_DIV, '0);
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_MUL, '0);
		send_request(REQ_PUSH, 31'd0);
		send_request(REQ_SUB, '0);
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_MUL, '0);
	endtask

	task automatic test_overflow();
		while (mirror_depth < STACK_DEPTH) begin
			send_request(REQ_PUSH, rand_number());
		end
		send_request(REQ_PUSH, NUM_MAX);
		send_request(REQ_PUSH, '0);
		send_request(REQ_NOP, '0);
		send_request(REQ_ADD, '0);
		send_request(REQ_PUSH, 31'd9);
	endtask

	task automatic test_underflow();
		while (mirror_depth > 1) begin
			send_request(REQ_W'($urandom_range(REQ_ADD, REQ_MUL)), rand_number());
		end
		send_request(REQ_ADD, '0);
		send_request(REQ_SUB, '0);
		send_request(REQ_MUL, '0);
		send_request(REQ_DIV, '0);
	endtask

	task automatic test_random_stream();
		int sent;
		int burst;
		int push_pct;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(30, 60);
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: push_pct = 90;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			repeat (burst) begin
				send_request(rand_kind(push_pct), rand_number());
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.number = '0;
		rsp_ch.ready = 1'b0;
		mirror_depth = 0;
		mismatches = 0;
		idle_cycles = 0;
		ready_hold = 0;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_arithmetic();
		test_saturation();
		test_overflow();
		test_underflow();
		test_random_stream();

		req_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** rpn_integer_stack_calculator: PASSED **");
		end else begin
			$display("** rpn_integer_stack_calculator: FAILED **");
		end
		$finish;
	end

endmodule

/* rpn_integer_stack_calculator.f */
rtl/rpn_pkg.sv
rtl/rpn_if.sv
rtl/rpn_ram.sv
rtl/rpn_alu.sv
rtl/rpn_integer_stack_calculator.sv
dv/tb_rpn_integer_stack_calculator.sv
